@@ design/cnf_clause_tautology_duplicate_check_unit_macros.svh @@
// ----------------------------------------------------------------------------
// CNF clause check assertion macros
// Concurrent assertion helpers shared by the clause check unit.
// ----------------------------------------------------------------------------
`ifndef CNF_CLAUSE_TAUTOLOGY_DUPLICATE_CHECK_UNIT_MACROS_SVH
`define CNF_CLAUSE_TAUTOLOGY_DUPLICATE_CHECK_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication check, sampled on the rising clock, disabled during reset.
`define CCTD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Check that a condition seen at one edge leads to another at the next edge.
`define CCTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define CCTD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define CCTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

@@ design/cctd_pkg.sv @@
// ----------------------------------------------------------------------------
// CNF clause check package
// Types and fixed constants shared by the clause check controller and datapath.
// ----------------------------------------------------------------------------
package cctd_pkg;

  localparam int LIT_W = 14;
  localparam int VAR_W = 13;
  localparam int CNT_W = 32;
  localparam int FLAG_W = 4;

  localparam logic [VAR_W-1:0] MAX_VAR_RST = 13'd4096;

  // Bit positions inside the sticky flag register.
  localparam int FLAG_TAUT = 0;
  localparam int FLAG_DUP  = 1;
  localparam int FLAG_EMPTY = 2;
  localparam int FLAG_OOR  = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } state_t;

  typedef struct packed {
    logic clr_we;
    logic load;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } status_t;

endpackage

@@ design/cnf_clause_tautology_duplicate_check_unit.sv @@
// ----------------------------------------------------------------------------
// CNF clause tautology and duplicate check unit
// Each input beat goes through the read and evaluate states to its result beat;
// the stamp table read then read-modify-write of one literal ends before the
// next beat. After reset a sweep zeroes all 2*MAX_VARS+1 entries, input stalled.
// ----------------------------------------------------------------------------
`include "cnf_clause_tautology_duplicate_check_unit_macros.svh"

module cnf_clause_tautology_duplicate_check_unit #(
  parameter int MAX_VARS = 4096,
  parameter int STAMP_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cctd_pkg::VAR_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [cctd_pkg::LIT_W-1:0] in_literal,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_clause_done,
  output logic [cctd_pkg::CNT_W-1:0]        out_kept_clauses,
  output logic [cctd_pkg::VAR_W-1:0]        out_used_vars,
  output logic                              out_has_tautology,
  output logic                              out_has_duplicate,
  output logic                              out_saw_empty,
  output logic                              out_out_of_range
);

  import cctd_pkg::*;

  // The controller walks each literal through three steps: the beat is
  // captured in the idle state, the table is read at both the literal and
  // its negation, and the evaluate step updates the clause state and writes
  // the current clause stamp back. The evaluate step waits there only when
  // the previous result beat is still held by a stalled receiver, so a new
  // literal may be captured and read while a result waits to be taken.
  cmd_t    cmd;
  status_t status;

  cctd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath holds the stamp table, the per-clause registers, the
  // saturating kept-clause count, the largest used variable and the sticky
  // flags. These registers are the result beat itself, since they change
  // only when a new result is committed.
  cctd_datapath #(
    .MAX_VARS   (MAX_VARS),
    .STAMP_BITS (STAMP_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_literal        (in_literal),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_clause_done   (out_clause_done),
    .out_kept_clauses  (out_kept_clauses),
    .out_used_vars     (out_used_vars),
    .out_has_tautology (out_has_tautology),
    .out_has_duplicate (out_has_duplicate),
    .out_saw_empty     (out_saw_empty),
    .out_out_of_range  (out_out_of_range)
  );

  // Only one literal is in flight, so an accepted beat closes the input.
  `CCTD_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall, "second beat accepted while busy")
  // A commit must never overwrite a result beat that is still stalled.
  `CCTD_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.commit, !(out_valid && out_stall), "result overwritten")
  // No literal may enter while the clearing sweep is still writing zeros.
  `CCTD_ASSERT_IMPL(a_clear_blocks, clk, rst_n, cmd.clr_we, in_stall && !cmd.commit, "beat taken during clear")

endmodule

@@ design/cctd_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, with registered read data.
// ----------------------------------------------------------------------------
module cctd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a_r,
  output logic [WIDTH-1:0] rdata_b_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

endmodule

@@ design/cctd_ctrl.sv @@
// ----------------------------------------------------------------------------
// CNF clause check controller
// Sequences the table clearing sweep and the read, evaluate steps per beat.
// ----------------------------------------------------------------------------
module cctd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  cctd_pkg::status_t status,
  output cctd_pkg::cmd_t    cmd
);

  import cctd_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd.clr_we = (state_r == ST_CLEAR);
    cmd.load   = (state_r == ST_IDLE) && in_valid;
    cmd.commit = (state_r == ST_EVAL) && status.out_free;
    in_stall   = (state_r != ST_IDLE);
  end

endmodule

@@ design/cctd_datapath.sv @@
// ----------------------------------------------------------------------------
// CNF clause check datapath
// Stamp table, clause state, counters, sticky flags and the result register.
// ----------------------------------------------------------------------------
module cctd_datapath #(
  parameter int MAX_VARS = 4096,
  parameter int STAMP_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cctd_pkg::cmd_t                      cmd,
  output cctd_pkg::status_t                   status,
  input  logic                                cfg_we,
  input  logic [cctd_pkg::VAR_W-1:0]          cfg_wdata,
  input  logic signed [cctd_pkg::LIT_W-1:0]   in_literal,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_clause_done,
  output logic [cctd_pkg::CNT_W-1:0]          out_kept_clauses,
  output logic [cctd_pkg::VAR_W-1:0]          out_used_vars,
  output logic                                out_has_tautology,
  output logic                                out_has_duplicate,
  output logic                                out_saw_empty,
  output logic                                out_out_of_range
);

  import cctd_pkg::*;

  localparam int DEPTH = 2 * MAX_VARS + 1;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [VAR_W-1:0]        max_var_r;
  logic signed [LIT_W-1:0] lit_r;
  logic [AW-1:0]           clr_cnt_r;
  logic [STAMP_BITS-1:0]   stamp_r, stamp_nxt;
  logic [VAR_W-1:0]        cmax_r, cmax_nxt;
  logic                    skip_r, skip_nxt;
  logic [CNT_W-1:0]        kept_r, kept_nxt;
  logic [VAR_W-1:0]        used_r, used_nxt;
  logic [FLAG_W-1:0]       flags_r, flags_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    done_r;

  logic signed [31:0]      lit_ext;
  logic signed [31:0]      pos_w, neg_w;
  logic [31:0]             mag_w, limit_w;
  logic                    is_zero, oor;
  logic [STAMP_BITS-1:0]   rd_pos, rd_neg;
  logic                    record;
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [STAMP_BITS-1:0]   ram_wdata;

  // Table addressing: entry index is literal + MAX_VARS.
  always_comb begin
    lit_ext = 32'(lit_r);
    pos_w   = lit_ext + 32'(MAX_VARS);
    neg_w   = 32'(MAX_VARS) - lit_ext;
    mag_w   = (lit_r < 0) ? 32'(-lit_ext) : 32'(lit_ext);
    limit_w = (32'(max_var_r) < 32'(MAX_VARS)) ? 32'(max_var_r) : 32'(MAX_VARS);
    is_zero = (lit_r == '0);
    oor     = (mag_w > limit_w);
  end

  cctd_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (DEPTH)
  ) u_stamp_ram (
    .clk       (clk),
    .we        (ram_we),
    .waddr     (ram_waddr),
    .wdata     (ram_wdata),
    .raddr_a   (pos_w[AW-1:0]),
    .raddr_b   (neg_w[AW-1:0]),
    .rdata_a_r (rd_pos),
    .rdata_b_r (rd_neg)
  );

  always_comb begin
    stamp_nxt = stamp_r;
    cmax_nxt  = cmax_r;
    skip_nxt  = skip_r;
    kept_nxt  = kept_r;
    used_nxt  = used_r;
    flags_nxt = flags_r;
    record    = 1'b0;
    if (cmd.commit) begin
      if (is_zero) begin
        if (!skip_r) begin
          if (kept_r != '1) begin
            kept_nxt = kept_r + 1'b1;
          end
          if (cmax_r == '0) begin
            flags_nxt[FLAG_EMPTY] = 1'b1;
          end else if (cmax_r > used_r) begin
            used_nxt = cmax_r;
          end
        end
        stamp_nxt = stamp_r + 1'b1;
        cmax_nxt  = '0;
        skip_nxt  = 1'b0;
      end else if (!skip_r) begin
        priority if (oor) begin
          flags_nxt[FLAG_OOR] = 1'b1;
        end else if (rd_neg == stamp_r) begin
          flags_nxt[FLAG_TAUT] = 1'b1;
          skip_nxt = 1'b1;
        end else if (rd_pos != stamp_r) begin
          record = 1'b1;
          if (mag_w[VAR_W-1:0] > cmax_r) begin
            cmax_nxt = mag_w[VAR_W-1:0];
          end
        end else begin
          flags_nxt[FLAG_DUP] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    ram_we    = cmd.clr_we || record;
    ram_waddr = cmd.clr_we ? clr_cnt_r : pos_w[AW-1:0];
    ram_wdata = cmd.clr_we ? '0 : stamp_r;
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    status.out_free = !out_valid_r || !out_stall;
    status.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_var_r   <= MAX_VAR_RST;
      clr_cnt_r   <= '0;
      stamp_r     <= STAMP_BITS'(1);
      cmax_r      <= '0;
      skip_r      <= 1'b0;
      kept_r      <= '0;
      used_r      <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_var_r <= cfg_wdata;
      end
      if (cmd.clr_we) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      stamp_r     <= stamp_nxt;
      cmax_r      <= cmax_nxt;
      skip_r      <= skip_nxt;
      kept_r      <= kept_nxt;
      used_r      <= used_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lit_r <= in_literal;
    end
    if (cmd.commit) begin
      done_r <= is_zero;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clause_done   = done_r;
  assign out_kept_clauses  = kept_r;
  assign out_used_vars     = used_r;
  assign out_has_tautology = flags_r[FLAG_TAUT];
  assign out_has_duplicate = flags_r[FLAG_DUP];
  assign out_saw_empty     = flags_r[FLAG_EMPTY];
  assign out_out_of_range  = flags_r[FLAG_OOR];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Clause check unit testbench
// Streams tokenized CNF literals through the clause check unit. A tracker of
// its own follows clause stamps, per-clause peaks and the sticky flags, and
// every status beat from the unit is compared with it field by field.
// ----------------------------------------------------------------------------
module testbench;
  import cctd_pkg::*;

  localparam int MAX_VARS = 4096;
  localparam int TABLE_DEPTH = 2 * MAX_VARS + 1;
  // The clearing sweep after reset over all 2*MAX_VARS+1 table entries and
  // the long receiver hold-off both stay far below this limit.
  localparam int IDLE_LIMIT = 50000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Extra wait once no status beat is owed, before a setting or the end.
  localparam int DRAIN_CYCLES = 8;

  // One status beat as the unit should report it.
  typedef struct {
    logic             clause_done;
    logic [CNT_W-1:0] kept_clauses;
    logic [VAR_W-1:0] used_vars;
    logic             has_tautology;
    logic             has_duplicate;
    logic             saw_empty;
    logic             out_of_range;
  } clause_status_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [VAR_W-1:0]        cfg_wdata = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [LIT_W-1:0] in_literal = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_clause_done;
  logic [CNT_W-1:0]        out_kept_clauses;
  logic [VAR_W-1:0]        out_used_vars;
  logic                    out_has_tautology;
  logic                    out_has_duplicate;
  logic                    out_saw_empty;
  logic                    out_out_of_range;

  // Tracker state: which literals carry the stamp of the open clause, the
  // stamp itself, the largest variable of the open clause, and the totals.
  logic [31:0]       seen_stamp [0:TABLE_DEPTH-1];
  logic [31:0]       clause_id;
  logic [VAR_W-1:0]  clause_peak;
  logic              skip_rest;
  logic [CNT_W-1:0]  kept_total;
  logic [VAR_W-1:0]  peak_var;
  logic [FLAG_W-1:0] sticky;
  logic [VAR_W-1:0]  var_limit_reg;

  // Status beats still owed by the unit, oldest first.
  clause_status_t pending_status[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  cnf_clause_tautology_duplicate_check_unit #(
    .MAX_VARS(MAX_VARS),
    .STAMP_BITS(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_literal(in_literal),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_clause_done(out_clause_done),
    .out_kept_clauses(out_kept_clauses),
    .out_used_vars(out_used_vars),
    .out_has_tautology(out_has_tautology),
    .out_has_duplicate(out_has_duplicate),
    .out_saw_empty(out_saw_empty),
    .out_out_of_range(out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  function automatic void reset_tracker();
    for (int i = 0; i < TABLE_DEPTH; i++) seen_stamp[i] = '0;
    clause_id = 32'd1;
    clause_peak = '0;
    skip_rest = 1'b0;
    kept_total = '0;
    peak_var = '0;
    sticky = '0;
    var_limit_reg = MAX_VAR_RST;
  endfunction

  // Advance the tracker by one accepted literal and queue the status beat
  // that the unit owes for it. Every literal yields exactly one beat.
  function automatic void track_literal(logic signed [LIT_W-1:0] lit);
    int value;
    int mag;
    int limit;
    clause_status_t st;
    value = lit;
    mag = (value < 0) ? -value : value;
    limit = (var_limit_reg < MAX_VARS) ? int'(var_limit_reg) : MAX_VARS;
    if (value == 0) begin
      // A clause ends. A skipped (tautological) clause is not counted.
      if (!skip_rest) begin
        if (kept_total != '1) kept_total = kept_total + 1'b1;
        if (clause_peak == '0) begin
          sticky[FLAG_EMPTY] = 1'b1;
        end else if (clause_peak > peak_var) begin
          peak_var = clause_peak;
        end
      end
      clause_id = clause_id + 1'b1;
      clause_peak = '0;
      skip_rest = 1'b0;
    end else if (!skip_rest) begin
      if (mag > limit) begin
        // Too large a variable is flagged and otherwise dropped.
        sticky[FLAG_OOR] = 1'b1;
      end else if (seen_stamp[MAX_VARS - value] == clause_id) begin
        // The negation was already seen in this clause.
        sticky[FLAG_TAUT] = 1'b1;
        skip_rest = 1'b1;
      end else if (seen_stamp[MAX_VARS + value] != clause_id) begin
        seen_stamp[MAX_VARS + value] = clause_id;
        if (mag > clause_peak) clause_peak = VAR_W'(mag);
      end else begin
        sticky[FLAG_DUP] = 1'b1;
      end
    end
    st.clause_done = (value == 0);
    st.kept_clauses = kept_total;
    st.used_vars = peak_var;
    st.has_tautology = sticky[FLAG_TAUT];
    st.has_duplicate = sticky[FLAG_DUP];
    st.saw_empty = sticky[FLAG_EMPTY];
    st.out_of_range = sticky[FLAG_OOR];
    pending_status.push_back(st);
  endfunction

  function automatic void report_mismatch(string detail);
    if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, detail);
    mismatches++;
  endfunction

  // Offer one literal, with random idle cycles ahead of it, and hold it until
  // the unit takes it. in_valid stays high on return so that back-to-back
  // beats need no second assignment in the same step.
  task automatic send_literal(input int value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_literal <= LIT_W'(value);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_literal(in_literal);
  endtask

  // A clause of zero to six literals over variables 1..span. Most literals
  // are plain, some repeat or negate an earlier one of the clause, and a few
  // are arbitrary 14-bit noise, which can be out of range or even a zero.
  task automatic send_random_clause(input int span);
    int lits[$];
    int len;
    int pick;
    int value;
    logic signed [LIT_W-1:0] noise;
    len = $urandom_range(0, 6);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 8 && lits.size() > 0) begin
        value = lits[$urandom_range(lits.size() - 1)];
      end else if (pick < 16 && lits.size() > 0) begin
        value = -lits[$urandom_range(lits.size() - 1)];
      end else if (pick < 21) begin
        noise = LIT_W'($urandom_range((1 << LIT_W) - 1));
        value = noise;
      end else begin
        value = $urandom_range(1, span);
        if ($urandom_range(1)) value = -value;
      end
      lits.push_back(value);
      send_literal(value);
    end
    send_literal(0);
  endtask

  // The register may only change while nothing is in flight.
  task automatic write_max_var(input logic [VAR_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    var_limit_reg = value;
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Each sticky flag rises on its own: a clean clause, an empty clause, a
  // repeated literal, a tautology whose tail (even an out-of-range literal)
  // is skipped, and finally a magnitude beyond any limit.
  task automatic test_clause_flags();
    int seq[$];
    seq = '{1, -2, 0, 0, 3, 3, 0, 4, -4, 8191, 0, -8192, 5, 0};
    set_idling(0, 0);
    foreach (seq[i]) send_literal(seq[i]);
  endtask

  // Random clauses under each idling pattern, with the variable span growing
  // so that the largest used variable keeps moving.
  task automatic test_random_clauses();
    set_idling(0, 0);
    repeat (50) send_random_clause(16);
    set_idling(61, 0);
    repeat (50) send_random_clause(40);
    set_idling(0, 61);
    repeat (50) send_random_clause(100);
    set_idling(22, 22);
    repeat (50) send_random_clause(250);
  endtask

  // Limits from zero (every variable out of range) up to the all-ones value,
  // which the unit clips to MAX_VARS.
  task automatic test_max_var_settings();
    int settings[$];
    int span;
    settings = '{0, 7, $urandom_range(8, 200), 8191};
    set_idling(22, 22);
    foreach (settings[i]) begin
      write_max_var(VAR_W'(settings[i]));
      span = (settings[i] > 250) ? 600 : settings[i] + 8;
      repeat (12) send_random_clause(span);
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the unit fills up and stalls its input.
  task automatic test_output_backpressure();
    set_idling(0, 0);
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (15) send_random_clause(1000);
  endtask

  // The largest variables: a tautology on the extreme pair, a kept clause
  // with the extreme negative literal, a limit one below the top, and a
  // clipped limit that lets MAX_VARS in but nothing above it.
  task automatic test_extreme_variables();
    int seq[$];
    set_idling(0, 0);
    write_max_var(13'd4096);
    seq = '{-4096, 4096, 0, -4096, 0};
    foreach (seq[i]) send_literal(seq[i]);
    write_max_var(13'd4095);
    seq = '{4096, -4095, 0};
    foreach (seq[i]) send_literal(seq[i]);
    write_max_var(13'd8191);
    seq = '{4097, 4096, 0};
    foreach (seq[i]) send_literal(seq[i]);
  endtask

  // Receiver: checks each accepted status beat and decides the stall for
  // the next cycle, honoring a requested hold-off first.
  always @(posedge clk) begin : status_check
    clause_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_status.size() == 0) begin
          report_mismatch("status beat with nothing expected");
        end else begin
          want = pending_status.pop_front();
          if (out_clause_done !== want.clause_done
              || out_kept_clauses !== want.kept_clauses
              || out_used_vars !== want.used_vars
              || out_has_tautology !== want.has_tautology
              || out_has_duplicate !== want.has_duplicate
              || out_saw_empty !== want.saw_empty
              || out_out_of_range !== want.out_of_range) begin
            report_mismatch($sformatf(
              {"expected done=%0b kept=%0d used=%0d taut=%0b dup=%0b empty=%0b oor=%0b,",
               " got done=%0b kept=%0d used=%0d taut=%0b dup=%0b empty=%0b oor=%0b"},
              want.clause_done, want.kept_clauses, want.used_vars, want.has_tautology,
              want.has_duplicate, want.saw_empty, want.out_of_range,
              out_clause_done, out_kept_clauses, out_used_vars, out_has_tautology,
              out_has_duplicate, out_saw_empty, out_out_of_range));
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: too long without a beat on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stamp wrap and counter saturation need 2^32-1 clauses and lie beyond
  // any practical run, so no stimulus aims at them.
  initial begin
    reset_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_clause_flags();
    test_random_clauses();
    test_max_var_settings();
    test_output_backpressure();
    test_extreme_variables();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
